>>> src/afskcd_pkg.sv
`default_nettype none

package afskcd_pkg;

   // fixed field widths
   localparam int PHASE_W = 16;
   localparam int STEP_W  = 15;
   localparam logic [STEP_W-1:0] STEP_RESET = 15'd7133;

   // four correlations per beat: mark I/Q, then space I/Q
   localparam int NCORR = 4;

   // tone and rate constants
   localparam logic [63:0] MARK_HZ  = 64'd3970;
   localparam logic [63:0] SPACE_HZ = 64'd2165;
   localparam logic [63:0] RATE_HZ  = 64'd22050;

   // Q30 constants
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam longint      ONE_Q30_S   = 64'sd1073741824;
   localparam longint      HAM_A_Q30   = 64'sd579820585;
   localparam longint      HAM_B_Q30   = 64'sd493921239;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

   // where a product of the shared multiplier goes
   typedef enum logic [2:0] {
      DEST_NONE,
      DEST_ACC,
      DEST_LO,
      DEST_MID,
      DEST_HI
   } mul_dest_type;

   typedef struct packed {
      mul_dest_type dest;
      logic         space;
   } mul_tag_type;

   // elaboration-time helpers for the coefficient tables
   function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[93:30];
   endfunction

   function automatic logic [63:0] poly_cut(input logic [63:0] p);
      return (p > ONE_Q30) ? 64'd0 : (ONE_Q30 - p);
   endfunction

   function automatic logic [63:0] cos_poly(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      x2 = mul_q30(x, x);
      t  = ONE_Q30;
      t  = poly_cut(mul_q30(t, x2) / 64'd132);
      t  = poly_cut(mul_q30(t, x2) / 64'd90);
      t  = poly_cut(mul_q30(t, x2) / 64'd56);
      t  = poly_cut(mul_q30(t, x2) / 64'd30);
      t  = poly_cut(mul_q30(t, x2) / 64'd12);
      t  = poly_cut(mul_q30(t, x2) / 64'd2);
      return t;
   endfunction

   function automatic logic [63:0] sin_poly(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      x2 = mul_q30(x, x);
      t  = ONE_Q30;
      t  = poly_cut(mul_q30(t, x2) / 64'd110);
      t  = poly_cut(mul_q30(t, x2) / 64'd72);
      t  = poly_cut(mul_q30(t, x2) / 64'd42);
      t  = poly_cut(mul_q30(t, x2) / 64'd20);
      t  = poly_cut(mul_q30(t, x2) / 64'd6);
      return mul_q30(x, t);
   endfunction

   // cosine of a 32-bit turn fraction, Q30
   function automatic longint cos_turn(input logic [31:0] t);
      logic [1:0]  q;
      logic [63:0] x;
      longint      c;
      longint      s;
      q = t[31:30];
      x = ({34'd0, t[29:0]} * HALF_PI_Q30) >> 30;
      c = $signed(cos_poly(x));
      s = $signed(sin_poly(x));
      case (q)
         2'd0:    return c;
         2'd1:    return -s;
         2'd2:    return -c;
         default: return s;
      endcase
   endfunction

   // num / RATE_HZ of a turn, rounded, as a 32-bit fraction
   function automatic logic [31:0] frac_turn_rate(input logic [63:0] num);
      logic [63:0] r;
      r = ((num << 32) + RATE_HZ / 2) / RATE_HZ;
      return r[31:0];
   endfunction

   // tone * window, rounded half up in magnitude, saturated, sign of tone
   function automatic longint make_coef(input longint tone, input longint w, input int cw);
      logic        neg;
      logic [63:0] mag;
      logic [63:0] lim;
      logic [63:0] p;
      logic [63:0] r;
      neg = (tone < 0);
      mag = neg ? $unsigned(-tone) : $unsigned(tone);
      lim = (64'd1 << (cw - 1)) - 64'd1;
      p   = mag * $unsigned(w);
      r   = (p + (64'd1 << (60 - cw))) >> (61 - cw);
      if (r > lim) begin
         r = lim;
      end
      return neg ? -$signed(r) : $signed(r);
   endfunction

endpackage

`default_nettype wire

>>> src/afsk_correlator_demodulator_unit.sv
`default_nettype none

// Channel | Dir | Handshake            | Payload
// --------+-----+----------------------+----------------------------------
// req     | in  | req_valid/req_stall  | req_sample (SAMPLE_WIDTH, signed)
// rsp     | out | rsp_valid/rsp_stall  | rsp_rx_bit, rsp_tone_is_mark
// csr     | in  | csr_wr_en            | csr_wr_data (phase step, 15 bits)
//
// Between one acceptance and the next, the single shared multiplier does TAPS
// MACs plus three partial squares for each of the four correlations, one
// product per cycle.
// Reset is synchronous, active high; it clears the window, tone and phase
// history and restores the phase step to 7133.
// req_stall is high while a beat is in progress. The result sits in an
// output register; a beat can be taken while it waits, and the phase update
// holds off until that register is free.

module afsk_correlator_demodulator_unit #(
   parameter int TAPS         = 18,
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // sample in
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0]   req_sample,
   // bit out
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic                                  rsp_rx_bit,
   output logic                                  rsp_tone_is_mark,
   // phase step register
   input  wire                                   csr_wr_en,
   input  wire logic [afskcd_pkg::STEP_W-1:0]    csr_wr_data
);
   import afskcd_pkg::*;

   // widths
   localparam int TAP_IW = $clog2(TAPS);
   localparam int ACC_W  = SAMPLE_WIDTH + COEF_WIDTH + $clog2(TAPS);
   localparam int HALF_W = (ACC_W + 1) / 2;
   localparam int MAX_SC = (SAMPLE_WIDTH > COEF_WIDTH) ? SAMPLE_WIDTH : COEF_WIDTH;
   localparam int MUL_W  = (MAX_SC > HALF_W + 1) ? MAX_SC : HALF_W + 1;
   localparam int EN_W   = 2 * ACC_W + 1;

   localparam logic [TAP_IW-1:0] TAP_LAST = TAP_IW'(TAPS - 1);
   localparam logic [1:0]        SEL_LAST = 2'(NCORR - 1);

   // partial products of a square: lo*lo, lo*hi (doubled), hi*hi
   localparam logic [1:0] PART_LO  = 2'd0;
   localparam logic [1:0] PART_MID = 2'd1;
   localparam logic [1:0] PART_HI  = 2'd2;

   localparam logic [PHASE_W:0] PHASE_HALF = 17'h0_8000;

   // ---------------------------------------------------------------------
   // coefficient tables, built at elaboration
   // sel: 0 mark cos, 1 mark sin, 2 space cos, 3 space sin
   // ---------------------------------------------------------------------
   function automatic logic signed [COEF_WIDTH-1:0] coef_value(input int sel, input int idx);
      logic [63:0] wt;
      longint      w;
      logic [63:0] freq;
      logic [31:0] turn;
      longint      tone;
      wt = ({32'd0, 32'(idx)} << 32) / 64'(TAPS - 1);
      w  = HAM_A_Q30 - (HAM_B_Q30 * cos_turn(wt[31:0])) / ONE_Q30_S;
      if (w < 0) begin
         w = 0;
      end
      if (w > ONE_Q30_S) begin
         w = ONE_Q30_S;
      end
      freq = (sel < 2) ? MARK_HZ : SPACE_HZ;
      turn = frac_turn_rate((64'(idx) * freq) % RATE_HZ);
      if ((sel % 2) == 1) begin
         turn = turn - QUARTER_TURN;
      end
      tone = cos_turn(turn);
      return COEF_WIDTH'(make_coef(tone, w, COEF_WIDTH));
   endfunction

   logic signed [COEF_WIDTH-1:0] coef_tab [NCORR][TAPS];

   for (genvar g = 0; g < TAPS; g++) begin : g_coef
      localparam logic signed [COEF_WIDTH-1:0] C_MI = coef_value(0, g);
      localparam logic signed [COEF_WIDTH-1:0] C_MQ = coef_value(1, g);
      localparam logic signed [COEF_WIDTH-1:0] C_SI = coef_value(2, g);
      localparam logic signed [COEF_WIDTH-1:0] C_SQ = coef_value(3, g);
      assign coef_tab[0][g] = C_MI;
      assign coef_tab[1][g] = C_MQ;
      assign coef_tab[2][g] = C_SI;
      assign coef_tab[3][g] = C_SQ;
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   typedef enum logic [2:0] {
      ST_IDLE,    // waiting for a sample
      ST_MAC,     // one tap per cycle, window rotates under tap 0
      ST_ACCW,    // last product lands in the accumulator
      ST_ABS,     // magnitude of the correlation
      ST_SQ,      // three partial squares into the energy
      ST_DRAIN,   // last partial square lands
      ST_CMP,     // mark versus space energy
      ST_PLL      // bit clock update and result
   } state_type;

   state_type                     state_ff, state_in;
   logic signed [SAMPLE_WIDTH-1:0] win_ff [TAPS];
   logic signed [SAMPLE_WIDTH-1:0] win_in [TAPS];
   logic [TAP_IW-1:0]             tap_ff, tap_in;
   logic [1:0]                    sel_ff, sel_in;
   logic [1:0]                    part_ff, part_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic [ACC_W-1:0]              mag_ff, mag_in;
   logic [EN_W-1:0]               mark_e_ff, mark_e_in;
   logic [EN_W-1:0]               space_e_ff, space_e_in;
   logic [1:0]                    tone_hist_ff, tone_hist_in;
   logic [1:0]                    samp_hist_ff, samp_hist_in;
   logic [PHASE_W-1:0]            phase_ff, phase_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_rx_bit_ff, rsp_rx_bit_in;
   logic                          rsp_mark_ff, rsp_mark_in;

   // shared multiplier hookup
   logic signed [MUL_W-1:0]       op_a, op_b;
   mul_tag_type                   tag_in;
   logic signed [2*MUL_W-1:0]     mul_prod;
   mul_tag_type                   mul_tag;

   // misc combinational
   logic                          accept;
   logic                          out_free;
   logic [MUL_W-1:0]              mag_lo, mag_hi;
   logic [EN_W-1:0]               sq_term, sq_add;
   logic                          tone_change;
   logic [PHASE_W:0]              phase_thr, phase_adj, phase_sum;
   logic                          wrap;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign mag_lo   = MUL_W'(mag_ff[HALF_W-1:0]);
   assign mag_hi   = MUL_W'(mag_ff[ACC_W-1:HALF_W]);

   // partial square, placed at its weight
   always_comb begin
      sq_term = EN_W'(mul_prod[2*HALF_W-1:0]);
      case (mul_tag.dest)
         DEST_LO:  sq_add = sq_term;
         DEST_MID: sq_add = sq_term << (HALF_W + 1);
         DEST_HI:  sq_add = sq_term << (2 * HALF_W);
         default:  sq_add = '0;
      endcase
   end

   // bit clock: nudge toward the centre on a tone change, then step
   always_comb begin
      tone_change = tone_hist_ff[1] ^ tone_hist_ff[0];
      phase_thr   = PHASE_HALF - (PHASE_W + 1)'(step_ff[STEP_W-1:1]);
      phase_adj   = {1'b0, phase_ff};
      if (tone_change) begin
         if ({1'b0, phase_ff} < phase_thr) begin
            phase_adj = {1'b0, phase_ff} + (PHASE_W + 1)'(step_ff[STEP_W-1:3]);
         end else begin
            phase_adj = {1'b0, phase_ff} - (PHASE_W + 1)'(step_ff[STEP_W-1:3]);
         end
      end
      phase_sum = phase_adj + (PHASE_W + 1)'(step_ff);
      wrap      = phase_sum[PHASE_W];
   end

   always_comb begin
      state_in      = state_ff;
      win_in        = win_ff;
      tap_in        = tap_ff;
      sel_in        = sel_ff;
      part_in       = part_ff;
      acc_in        = acc_ff;
      mag_in        = mag_ff;
      mark_e_in     = mark_e_ff;
      space_e_in    = space_e_ff;
      tone_hist_in  = tone_hist_ff;
      samp_hist_in  = samp_hist_ff;
      phase_in      = phase_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_rx_bit_in = rsp_rx_bit_ff;
      rsp_mark_in   = rsp_mark_ff;
      op_a          = MUL_W'(win_ff[0]);
      op_b          = MUL_W'(coef_tab[sel_ff][tap_ff]);
      tag_in.dest   = DEST_NONE;
      tag_in.space  = sel_ff[1];

      if (csr_wr_en) begin
         step_in = csr_wr_data;
      end

      // products land wherever their tag says
      if (mul_tag.dest == DEST_ACC) begin
         acc_in = acc_ff + $signed(mul_prod[ACC_W-1:0]);
      end else if (mul_tag.dest != DEST_NONE) begin
         if (mul_tag.space) begin
            space_e_in = space_e_ff + sq_add;
         end else begin
            mark_e_in = mark_e_ff + sq_add;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               for (int i = 0; i < TAPS - 1; i++) begin
                  win_in[i] = win_ff[i+1];
               end
               win_in[TAPS-1] = req_sample;
               tap_in     = '0;
               sel_in     = '0;
               acc_in     = '0;
               mark_e_in  = '0;
               space_e_in = '0;
               state_in   = ST_MAC;
            end
         end
         ST_MAC: begin
            tag_in.dest = DEST_ACC;
            // rotate; after TAPS steps the window is back in place
            for (int i = 0; i < TAPS - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[TAPS-1] = win_ff[0];
            tap_in = tap_ff + 1'b1;
            if (tap_ff == TAP_LAST) begin
               tap_in   = '0;
               state_in = ST_ACCW;
            end
         end
         ST_ACCW: begin
            state_in = ST_ABS;
         end
         ST_ABS: begin
            mag_in   = acc_ff[ACC_W-1] ? $unsigned(-acc_ff) : $unsigned(acc_ff);
            part_in  = PART_LO;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            case (part_ff)
               PART_LO: begin
                  op_a        = $signed(mag_lo);
                  op_b        = $signed(mag_lo);
                  tag_in.dest = DEST_LO;
               end
               PART_MID: begin
                  op_a        = $signed(mag_lo);
                  op_b        = $signed(mag_hi);
                  tag_in.dest = DEST_MID;
               end
               default: begin
                  op_a        = $signed(mag_hi);
                  op_b        = $signed(mag_hi);
                  tag_in.dest = DEST_HI;
               end
            endcase
            part_in = part_ff + 1'b1;
            if (part_ff == PART_HI) begin
               if (sel_ff == SEL_LAST) begin
                  state_in = ST_DRAIN;
               end else begin
                  sel_in   = sel_ff + 1'b1;
                  acc_in   = '0;
                  state_in = ST_MAC;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            tone_hist_in = {tone_hist_ff[0], (mark_e_ff > space_e_ff)};
            state_in     = ST_PLL;
         end
         ST_PLL: begin
            // wait for the output register before touching the phase
            if (out_free) begin
               phase_in = phase_sum[PHASE_W-1:0];
               if (wrap) begin
                  samp_hist_in  = {samp_hist_ff[0], tone_hist_ff[0]};
                  rsp_valid_in  = 1'b1;
                  rsp_mark_in   = tone_hist_ff[0];
                  rsp_rx_bit_in = ~(samp_hist_ff[0] ^ tone_hist_ff[0]);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_ff       <= '{default: '0};
         tap_ff       <= '0;
         sel_ff       <= '0;
         part_ff      <= PART_LO;
         tone_hist_ff <= '0;
         samp_hist_ff <= '0;
         phase_ff     <= '0;
         step_ff      <= STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         tap_ff       <= tap_in;
         sel_ff       <= sel_in;
         part_ff      <= part_in;
         tone_hist_ff <= tone_hist_in;
         samp_hist_ff <= samp_hist_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      mag_ff        <= mag_in;
      mark_e_ff     <= mark_e_in;
      space_e_ff    <= space_e_in;
      rsp_rx_bit_ff <= rsp_rx_bit_in;
      rsp_mark_ff   <= rsp_mark_in;
   end

   afskcd_mul #(
      .MUL_W (MUL_W)
   ) u_mul (
      .clock    (clock),
      .reset    (reset),
      .op_a     (op_a),
      .op_b     (op_b),
      .tag_in   (tag_in),
      .mul_prod (mul_prod),
      .mul_tag  (mul_tag)
   );

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rx_bit       = rsp_rx_bit_ff;
   assign rsp_tone_is_mark = rsp_mark_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   a_sample_lands: assert property (@(posedge clock) disable iff (reset)
      accept |=> (win_ff[TAPS-1] == $past(req_sample)))
      else $error("accepted sample not at window head");

   a_mac_to_acc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |=> (mul_tag.dest == DEST_ACC))
      else $error("MAC product not routed to accumulator");

   a_result_from_pll: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_PLL))
      else $error("result raised outside bit clock update");

   a_nrzi: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PLL && out_free && wrap) |=>
         (rsp_valid_ff && rsp_tone_is_mark == samp_hist_ff[0]
          && rsp_rx_bit == (samp_hist_ff[0] == samp_hist_ff[1])))
      else $error("NRZI result does not match sampled tone history");

endmodule

`default_nettype wire

>>> src/afskcd_mul.sv
`default_nettype none

// shared signed multiplier, one registered stage; the tag travels alongside
module afskcd_mul #(
   parameter int MUL_W = 20
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire logic signed [MUL_W-1:0]   op_a,
   input  wire logic signed [MUL_W-1:0]   op_b,
   input  wire afskcd_pkg::mul_tag_type   tag_in,
   output logic signed [2*MUL_W-1:0]      mul_prod,
   output afskcd_pkg::mul_tag_type        mul_tag
);
   import afskcd_pkg::*;

   logic signed [2*MUL_W-1:0] prod_ff;
   logic signed [2*MUL_W-1:0] prod_in;
   mul_tag_type               tag_ff;

   assign prod_in = (2*MUL_W)'(op_a) * (2*MUL_W)'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.dest  <= DEST_NONE;
         tag_ff.space <= 1'b0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   assign mul_prod = prod_ff;
   assign mul_tag  = tag_ff;

endmodule

`default_nettype wire
